// ===== rtl/core/ogc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ogc_pkg
// shared constants, controller states and control/status bundles
// ----------------------------------------------------------------------------
package ogc_pkg;

	localparam int MAX_RANGES = 1024;
	localparam int AW = (MAX_RANGES > 2) ? $clog2(MAX_RANGES) : 1;
	localparam int CW = $clog2(MAX_RANGES + 1);
	localparam int SW = CW + 2;
	localparam int VW = 30;
	localparam int KW = 2 * VW;
	localparam int GW = 11;
	localparam logic [VW:0] WAYS_MOD = 31'd1000000007;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_SORT,
		ST_PASS,
		ST_RUN,
		ST_MRD,
		ST_MCMP,
		ST_SWI,
		ST_SWRD,
		ST_SWCMP,
		ST_POWI,
		ST_POW,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic sort_init;
		logic run_first;
		logic pass_end;
		logic run_set;
		logic take;
		logic sweep_init;
		logic sweep_step;
		logic sweep_mode;
		logic pow_init;
		logic pow_step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic pass_done;
		logic run_done;
		logic k_last;
		logic sw_last;
		logic n_zero;
		logic pow_done;
		logic out_free;
	} stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/ogc_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ogc_in_if
// range input channel, valid/ready
// ----------------------------------------------------------------------------
interface ogc_in_if;
	logic                    valid;
	logic                    ready;
	logic [ogc_pkg::VW-1:0]  range_start;
	logic [ogc_pkg::VW-1:0]  range_end;
	logic                    last_range;

	modport source (output valid, range_start, range_end, last_range, input ready);
	modport sink   (input valid, range_start, range_end, last_range, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ogc_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ogc_out_if
// result output channel, valid/ready
// ----------------------------------------------------------------------------
interface ogc_out_if;
	logic                    valid;
	logic                    ready;
	logic [ogc_pkg::VW-1:0]  ways_mod;
	logic [ogc_pkg::GW-1:0]  group_count;
	logic                    overflowed;

	modport source (output valid, ways_mod, group_count, overflowed, input ready);
	modport sink   (input valid, ways_mod, group_count, overflowed, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ogc_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ogc_ram
// generic ram, one write port, two registered read ports
// ----------------------------------------------------------------------------
module ogc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int ABITS = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [ABITS-1:0] waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [ABITS-1:0] raddr0,
	input  wire logic [ABITS-1:0] raddr1,
	output      logic [WIDTH-1:0] rdata0,
	output      logic [WIDTH-1:0] rdata1
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata0 <= mem_q[raddr0];
		rdata1 <= mem_q[raddr1];
	end
endmodule
`default_nettype wire

// ===== rtl/core/ogc_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ogc_ctrl
// sequencer: load, merge sort passes, sweep, power, result
// ----------------------------------------------------------------------------
module ogc_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire logic           in_last,
	input  wire ogc_pkg::stat_t st,
	output      logic           in_ready,
	output      ogc_pkg::cmd_t  cmd
);
	ogc_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ogc_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ogc_pkg::ST_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (in_last) state_d = ogc_pkg::ST_SORT;
				end
			end
			ogc_pkg::ST_SORT: begin
				cmd.sort_init = 1'b1;
				state_d = ogc_pkg::ST_PASS;
			end
			ogc_pkg::ST_PASS: begin
				if (st.pass_done) begin
					state_d = ogc_pkg::ST_SWI;
				end else begin
					cmd.run_first = 1'b1;
					state_d = ogc_pkg::ST_RUN;
				end
			end
			ogc_pkg::ST_RUN: begin
				if (st.run_done) begin
					cmd.pass_end = 1'b1;
					state_d = ogc_pkg::ST_PASS;
				end else begin
					cmd.run_set = 1'b1;
					state_d = ogc_pkg::ST_MRD;
				end
			end
			ogc_pkg::ST_MRD: state_d = ogc_pkg::ST_MCMP;
			ogc_pkg::ST_MCMP: begin
				cmd.take = 1'b1;
				state_d = st.k_last ? ogc_pkg::ST_RUN : ogc_pkg::ST_MRD;
			end
			ogc_pkg::ST_SWI: begin
				cmd.sweep_init = 1'b1;
				state_d = st.n_zero ? ogc_pkg::ST_POWI : ogc_pkg::ST_SWRD;
			end
			ogc_pkg::ST_SWRD: begin
				cmd.sweep_mode = 1'b1;
				state_d = ogc_pkg::ST_SWCMP;
			end
			ogc_pkg::ST_SWCMP: begin
				cmd.sweep_mode = 1'b1;
				cmd.sweep_step = 1'b1;
				state_d = st.sw_last ? ogc_pkg::ST_POWI : ogc_pkg::ST_SWRD;
			end
			ogc_pkg::ST_POWI: begin
				cmd.pow_init = 1'b1;
				state_d = ogc_pkg::ST_POW;
			end
			ogc_pkg::ST_POW: begin
				if (st.pow_done) begin
					state_d = ogc_pkg::ST_FIN;
				end else begin
					cmd.pow_step = 1'b1;
				end
			end
			ogc_pkg::ST_FIN: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_d = ogc_pkg::ST_LOAD;
				end
			end
			default: state_d = ogc_pkg::ST_LOAD;
		endcase
	end
endmodule
`default_nettype wire

// ===== rtl/core/ogc_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ogc_dp
// datapath: range stores, merge pointers, group sweep, modular power, result
// ----------------------------------------------------------------------------
module ogc_dp (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire ogc_pkg::cmd_t          cmd,
	output      ogc_pkg::stat_t         st,
	input  wire logic [ogc_pkg::VW-1:0] in_start,
	input  wire logic [ogc_pkg::VW-1:0] in_end,
	output      logic                   res_valid,
	input  wire logic                   res_ready,
	output      logic [ogc_pkg::VW-1:0] res_ways,
	output      logic [ogc_pkg::GW-1:0] res_groups,
	output      logic                   res_ovf
);
	localparam int AW = ogc_pkg::AW;
	localparam int CW = ogc_pkg::CW;
	localparam int SW = ogc_pkg::SW;
	localparam int VW = ogc_pkg::VW;
	localparam int KW = ogc_pkg::KW;

	logic [CW-1:0] count_q, n_q, groups_q, pcnt_q;
	logic          ovf_q, ovf_set_q, src_q, res_valid_q;
	logic [SW-1:0] w_q, l_q, mid_q, hi_q, i_q, j_q, k_q;
	logic [VW-1:0] run_end_q, ways_q;
	logic [VW-1:0] out_ways_q;
	logic [ogc_pkg::GW-1:0] out_groups_q;
	logic          out_ovf_q;

	logic          full;
	logic [SW-1:0] n_ext, lw, l2w, mid_d, hi_d;
	logic [KW-1:0] a0, b0, a1, b1, rd0, rd1, wdata;
	logic [AW-1:0] waddr, raddr0, raddr1;
	logic          we_a, we_b, take_i;
	logic [VW-1:0] ks, ke;
	logic [VW:0]   dbl;

	assign full  = (count_q == CW'(ogc_pkg::MAX_RANGES));
	assign n_ext = SW'(n_q);
	assign lw    = l_q + w_q;
	assign l2w   = l_q + (w_q << 1);
	assign mid_d = (lw  > n_ext) ? n_ext : lw;
	assign hi_d  = (l2w > n_ext) ? n_ext : l2w;

	// src_q low: store a holds the current order, b receives the merge
	assign rd0 = src_q ? b0 : a0;
	assign rd1 = src_q ? b1 : a1;
	assign take_i = (i_q < mid_q) && ((j_q >= hi_q) || (rd0 <= rd1));

	assign raddr0 = cmd.sweep_mode ? k_q[AW-1:0] : i_q[AW-1:0];
	assign raddr1 = j_q[AW-1:0];
	assign waddr  = cmd.load ? count_q[AW-1:0] : k_q[AW-1:0];
	assign wdata  = cmd.load ? {in_start, in_end} : (take_i ? rd0 : rd1);
	assign we_a   = (cmd.load && !full) || (cmd.take && src_q);
	assign we_b   = cmd.take && !src_q;

	ogc_ram #(.WIDTH(KW), .DEPTH(ogc_pkg::MAX_RANGES)) u_ram_a (
		.clk(clk), .we(we_a), .waddr(waddr), .wdata(wdata),
		.raddr0(raddr0), .raddr1(raddr1), .rdata0(a0), .rdata1(a1)
	);
	ogc_ram #(.WIDTH(KW), .DEPTH(ogc_pkg::MAX_RANGES)) u_ram_b (
		.clk(clk), .we(we_b), .waddr(waddr), .wdata(wdata),
		.raddr0(raddr0), .raddr1(raddr1), .rdata0(b0), .rdata1(b1)
	);

	assign ks  = rd0[KW-1:VW];
	assign ke  = rd0[VW-1:0];
	assign dbl = {ways_q, 1'b0};

	// load counter and overflow mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.load) begin
			if (full) begin
				ovf_q <= 1'b1;
			end else begin
				count_q <= count_q + 1'b1;
			end
		end else if (cmd.sort_init) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end
	end

	// set size and overflow are captured before the counter clears
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q       <= full ? count_q : count_q + 1'b1;
			ovf_set_q <= ovf_q | full;
		end
	end

	// merge pointers, sweep and power registers
	always_ff @(posedge clk) begin
		if (cmd.sort_init) begin
			w_q   <= SW'(1);
			src_q <= 1'b0;
		end
		if (cmd.run_first) l_q <= '0;
		if (cmd.pass_end) begin
			w_q   <= w_q << 1;
			src_q <= ~src_q;
		end
		if (cmd.run_set) begin
			mid_q <= mid_d;
			hi_q  <= hi_d;
			i_q   <= l_q;
			j_q   <= mid_d;
			k_q   <= l_q;
		end
		if (cmd.take) begin
			if (take_i) i_q <= i_q + 1'b1;
			else        j_q <= j_q + 1'b1;
			k_q <= k_q + 1'b1;
			if (k_q + 1'b1 == hi_q) l_q <= hi_q;
		end
		if (cmd.sweep_init) begin
			k_q       <= '0;
			groups_q  <= '0;
			run_end_q <= '0;
		end
		if (cmd.sweep_step) begin
			k_q <= k_q + 1'b1;
			if (groups_q != '0 && ks <= run_end_q) begin
				if (ke > run_end_q) run_end_q <= ke;
			end else begin
				groups_q  <= groups_q + 1'b1;
				run_end_q <= ke;
			end
		end
		if (cmd.pow_init) begin
			ways_q <= VW'(1);
			pcnt_q <= groups_q;
		end
		if (cmd.pow_step) begin
			ways_q <= (dbl >= ogc_pkg::WAYS_MOD) ? VW'(dbl - ogc_pkg::WAYS_MOD) : VW'(dbl);
			pcnt_q <= pcnt_q - 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_ways_q   <= ways_q;
			out_groups_q <= ogc_pkg::GW'(groups_q);
			out_ovf_q    <= ovf_set_q;
		end
	end

	assign res_valid  = res_valid_q;
	assign res_ways   = out_ways_q;
	assign res_groups = out_groups_q;
	assign res_ovf    = out_ovf_q;

	assign st.pass_done = (w_q >= n_ext);
	assign st.run_done  = (l_q >= n_ext);
	assign st.k_last    = (k_q + 1'b1 == hi_q);
	assign st.sw_last   = (k_q + 1'b1 == n_ext);
	assign st.n_zero    = (n_q == '0);
	assign st.pow_done  = (pcnt_q == '0);
	assign st.out_free  = !res_valid_q || res_ready;

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(ogc_pkg::MAX_RANGES))
		else $error("load count beyond capacity");
	a_take_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |-> (k_q < hi_q) && (i_q <= mid_q) && (j_q <= hi_q))
		else $error("merge write outside its run");
	a_ways_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pow_step |=> (VW + 1)'(ways_q) < ogc_pkg::WAYS_MOD)
		else $error("power residue out of range");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!res_valid_q || res_ready))
		else $error("result overwritten before transaction");
endmodule
`default_nettype wire

// ===== rtl/core/overlap_group_counter_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// overlap_group_counter_core
// counts groups of overlapping inclusive ranges and two to that count mod 1e9+7
// ----------------------------------------------------------------------------
// Ranges arrive one transaction per cycle on rng and are written into a store
// of MAX_RANGES entries; a range that arrives with the store full is dropped
// and reported through overflowed. The transaction with last_range set closes
// the set: rng.ready falls, the stored {start,end} keys are sorted by a
// bottom-up merge sort that ping-pongs between two memories (ceil(log2 n)
// passes, each key moving through a read-compare-write loop on the memory
// ports, with a setup step per run and per pass), then a sweep reads and
// compares each key in turn and a doubling loop doubles once per group for
// the power. The result sits in an output register, so loading of the next
// set starts while a result waits; a second result waits for the first to
// be taken.
module overlap_group_counter_core (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ogc_in_if.sink     rng,
	ogc_out_if.source  res
);
	ogc_pkg::cmd_t  cmd;
	ogc_pkg::stat_t st;

	// controller: sequences load, sort passes, sweep, power and result
	ogc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rng.valid),
		.in_last  (rng.last_range),
		.st       (st),
		.in_ready (rng.ready),
		.cmd      (cmd)
	);

	// datapath: stores, merge pointers, sweep, modular doubling, output register
	ogc_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.in_start   (rng.range_start),
		.in_end     (rng.range_end),
		.res_valid  (res.valid),
		.res_ready  (res.ready),
		.res_ways   (res.ways_mod),
		.res_groups (res.group_count),
		.res_ovf    (res.overflowed)
	);
endmodule
`default_nettype wire
